/* rtl/core/epd_pkg.sv */
`default_nettype none
package epd_pkg;

    // result kinds
    typedef enum logic [2:0] {
        KIND_MARK    = 3'd0,
        KIND_SAMPLE  = 3'd1,
        KIND_LEAD    = 3'd2,
        KIND_DEBUG   = 3'd3,
        KIND_SEQ_ERR = 3'd4
    } epd_kind_t;

    // one classified request between front and back
    typedef struct packed {
        epd_kind_t   kind;
        logic [31:0] seq;
        logic [4:0]  channel;
        logic [31:0] raw;
        logic [7:0]  lead_bits;
        logic [2:0]  lead_idx;
        logic [7:0]  mark;
        logic [7:0]  dbg;
        logic        last;
    } epd_item_t;

    // packet layout
    localparam logic [7:0] WIN_EXTRA    = 8'd21;   // header 8 + lead-off 8 + checksum 1 + 4
    localparam logic [7:0] HEADER_BYTES = 8'd8;
    localparam logic [7:0] LEAD_BYTES   = 8'd8;

    // register map
    localparam logic [2:0] ADDR_CHANNEL_COUNT = 3'd0;
    localparam logic [5:0] CHANNEL_RESET      = 6'd32;

    // reciprocal of three, exact for 32-bit operands after a shift by 33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    // queue depth between front and back
    localparam int Q_DEPTH = 4;

endpackage
`default_nettype wire

/* rtl/core/epd_front.sv */
`default_nettype none
module epd_front #(
    parameter int WINDOW_DEPTH = 256,
    parameter int MAX_CHANNELS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [5:0]         channel_count,
    input  wire logic               cfg_wr,
    input  wire logic               in_valid,
    input  wire logic               in_flush,
    input  wire logic [7:0]         in_byte,
    output logic                    in_ready,
    input  wire logic               q_full,
    output logic                    push,
    output epd_pkg::epd_item_t      push_item
);
    import epd_pkg::*;

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [5:0] MAX_N = 6'(MAX_CHANNELS);

    logic [7:0]    win_mem [WINDOW_DEPTH];

    logic [AW-1:0] wp_reg, wp_next;
    logic [7:0]    fill_reg;
    logic          locked_reg;
    logic [31:0]   last_seq_reg;
    logic [7:0]    pos_reg;
    logic [31:0]   hs_reg;
    logic [7:0]    dbg_reg;
    logic [23:0]   wacc_reg;
    logic [7:0]    tap_reg [4];
    logic [7:0]    hist_reg [3];
    logic [7:0]    rd_data_reg;
    logic [2:0]    rf_cnt_reg;

    logic [5:0]    n_used;
    logic [7:0]    four_n, wlen, fill_eff, fill_new;
    logic          full_before, accept, step, do_parse;
    logic [7:0]    xb;

    // parser next values
    logic          p_locked, p_emit;
    logic [7:0]    p_pos, p_dbg, off, idx;
    logic [31:0]   p_hs, p_lastseq;
    logic [23:0]   p_wacc;
    logic [8:0]    allowed;
    logic [7:0]    mask;
    epd_item_t     p_item;

    logic          locked_mid, hunt_hit;
    logic [31:0]   w1, w2;

    logic [2:0]    tap_ofs;
    logic [7:0]    rd_dist;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] rd_addr;

    // packet geometry
    assign n_used      = (channel_count > MAX_N) ? MAX_N : channel_count;
    assign four_n      = {n_used, 2'b00};
    assign wlen        = WIN_EXTRA + four_n;
    assign fill_eff    = (fill_reg > wlen) ? wlen : fill_reg;
    assign full_before = (fill_eff == wlen);
    assign fill_new    = full_before ? wlen : fill_eff + 8'd1;

    assign in_ready = !q_full && (rf_cnt_reg == 3'd0);
    assign accept   = in_valid && in_ready;
    assign step     = accept && !in_flush;
    assign xb       = tap_reg[3];
    assign do_parse = step && locked_reg && full_before;

    // parse the byte leaving the window
    always_comb begin
        p_locked  = locked_reg;
        p_pos     = pos_reg;
        p_hs      = hs_reg;
        p_dbg     = dbg_reg;
        p_wacc    = wacc_reg;
        p_lastseq = last_seq_reg;
        p_emit    = 1'b0;
        p_item    = '0;
        off       = pos_reg - HEADER_BYTES;
        idx       = off - four_n;
        allowed   = {2'b00, n_used, 1'b0} - {3'b000, idx[2:0], 3'b000};
        if ($signed(allowed) >= 9'sd8) begin
            mask = 8'hFF;
        end else if ($signed(allowed) <= 9'sd0) begin
            mask = 8'h00;
        end else begin
            mask = (8'd1 << allowed[2:0]) - 8'd1;
        end
        if (pos_reg < 8'd4) begin
            p_hs = ((pos_reg == 8'd0) ? 32'd0 : hs_reg)
                   | ({24'd0, xb} << {pos_reg[1:0], 3'b000});
            if (pos_reg == 8'd3 && (last_seq_reg + 32'd1) != p_hs) begin
                p_locked    = 1'b0;
                p_pos       = 8'd0;
                p_dbg       = 8'd0;
                p_emit      = 1'b1;
                p_item.kind = KIND_SEQ_ERR;
                p_item.last = 1'b1;
            end else begin
                if (pos_reg == 8'd3) begin
                    p_lastseq = p_hs;
                end
                p_pos = pos_reg + 8'd1;
            end
        end else if (pos_reg < 8'd7) begin
            if (pos_reg == 8'd6) begin
                p_dbg = xb;
            end
            p_pos = pos_reg + 8'd1;
        end else if (pos_reg == 8'd7) begin
            p_pos = HEADER_BYTES;
            if (dbg_reg == 8'd0) begin
                p_emit      = 1'b1;
                p_item.kind = KIND_MARK;
                p_item.mark = xb;
            end
        end else if (dbg_reg != 8'd0) begin
            p_dbg       = dbg_reg - 8'd1;
            p_emit      = 1'b1;
            p_item.kind = KIND_DEBUG;
            p_item.dbg  = xb;
            if (dbg_reg == 8'd1) begin
                p_item.last = 1'b1;
                p_pos       = 8'd0;
            end
        end else if (off < four_n) begin
            p_pos = pos_reg + 8'd1;
            if (off[1:0] == 2'd3) begin
                p_emit         = 1'b1;
                p_item.kind    = KIND_SAMPLE;
                p_item.raw     = {xb, wacc_reg};
                p_item.channel = off[6:2];
            end else begin
                p_wacc = ((off[1:0] == 2'd0) ? 24'd0 : wacc_reg)
                         | ({16'd0, xb} << {off[1:0], 3'b000});
            end
        end else if (off < four_n + LEAD_BYTES) begin
            p_emit           = 1'b1;
            p_item.kind      = KIND_LEAD;
            p_item.lead_bits = xb & mask;
            p_item.lead_idx  = idx[2:0];
            p_item.last      = (idx[2:0] == 3'd7);
            p_pos            = pos_reg + 8'd1;
        end else begin
            p_pos = 8'd0;
        end
        p_item.seq = p_hs;
    end

    assign push      = do_parse && p_emit;
    assign push_item = p_item;

    // hunt check on the window after this byte
    assign locked_mid = do_parse ? p_locked : locked_reg;
    assign w1         = {rd_data_reg, tap_reg[0], tap_reg[1], tap_reg[2]};
    assign w2         = {in_byte, hist_reg[0], hist_reg[1], hist_reg[2]};
    assign hunt_hit   = !locked_mid && (fill_new == wlen) && ((w1 + 32'd1) == w2);

    // tap read address, one step ahead; reload sweep after a config write
    assign wp_next  = step ? ((wp_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1)
                           : wp_reg;
    assign tap_ofs  = (rf_cnt_reg >= 3'd2) ? 3'd5 - rf_cnt_reg : 3'd4;
    assign rd_dist  = wlen - {5'd0, tap_ofs};
    assign addr_sum = {1'b0, wp_next} + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(rd_dist);
    assign rd_addr  = (addr_sum >= (AW+1)'(WINDOW_DEPTH))
                      ? AW'(addr_sum - (AW+1)'(WINDOW_DEPTH)) : AW'(addr_sum);

    // window memory
    always_ff @(posedge aclk) begin
        if (step) begin
            win_mem[wp_reg] <= in_byte;
        end
        rd_data_reg <= win_mem[rd_addr];
    end

    // tap and input history shift lines
    always_ff @(posedge aclk) begin
        if (step || (rf_cnt_reg != 3'd0 && rf_cnt_reg <= 3'd4)) begin
            tap_reg[3] <= tap_reg[2];
            tap_reg[2] <= tap_reg[1];
            tap_reg[1] <= tap_reg[0];
            tap_reg[0] <= rd_data_reg;
        end
        if (step) begin
            hist_reg[2] <= hist_reg[1];
            hist_reg[1] <= hist_reg[0];
            hist_reg[0] <= in_byte;
        end
    end

    // window and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            fill_reg     <= 8'd0;
            locked_reg   <= 1'b0;
            last_seq_reg <= 32'd0;
            pos_reg      <= 8'd0;
            hs_reg       <= 32'd0;
            dbg_reg      <= 8'd0;
            wacc_reg     <= 24'd0;
            rf_cnt_reg   <= 3'd0;
        end else begin
            if (cfg_wr) begin
                rf_cnt_reg <= 3'd5;
            end else if (rf_cnt_reg != 3'd0) begin
                rf_cnt_reg <= rf_cnt_reg - 3'd1;
            end
            if (accept && in_flush) begin
                fill_reg   <= 8'd0;
                locked_reg <= 1'b0;
                pos_reg    <= 8'd0;
                dbg_reg    <= 8'd0;
                wacc_reg   <= 24'd0;
            end else if (step) begin
                wp_reg   <= wp_next;
                fill_reg <= fill_new;
                if (do_parse) begin
                    hs_reg   <= p_hs;
                    wacc_reg <= p_wacc;
                end
                if (hunt_hit) begin
                    locked_reg   <= 1'b1;
                    last_seq_reg <= w1 - 32'd1;
                    pos_reg      <= 8'd0;
                    dbg_reg      <= 8'd0;
                end else begin
                    locked_reg <= locked_mid;
                    if (do_parse) begin
                        last_seq_reg <= p_lastseq;
                        pos_reg      <= p_pos;
                        dbg_reg      <= p_dbg;
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/epd_fifo.sv */
`default_nettype none
module epd_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire epd_pkg::epd_item_t push_item,
    output logic                    full,
    output logic                    pop_valid,
    input  wire logic               pop,
    output epd_pkg::epd_item_t      pop_item
);
    import epd_pkg::*;

    localparam int PW = $clog2(Q_DEPTH);

    epd_item_t       buf_reg [Q_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg;
    logic            do_pop;

    assign full      = (count_reg == (PW+1)'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = buf_reg[rd_ptr_reg];
    assign do_pop    = pop && pop_valid;

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/epd_back.sv */
`default_nettype none
module epd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire epd_pkg::epd_item_t in_item,
    output logic                    in_ready,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output epd_pkg::epd_item_t      out_item,
    output logic [35:0]             out_scaled
);
    import epd_pkg::*;

    logic        a_valid_reg, b_valid_reg, o_valid_reg;
    epd_item_t   a_item_reg, b_item_reg, o_item_reg;
    logic [31:0] a_mag_reg, b_mag_reg;
    logic        a_neg_reg, b_neg_reg;
    logic [63:0] b_prod_reg;
    logic [35:0] o_scaled_reg;
    logic        ready_o, ready_b, ready_a;

    logic [30:0] quo;
    logic [1:0]  rem;
    logic [4:0]  frac;
    logic [35:0] mag36, scaled_next;

    assign ready_o  = !o_valid_reg || out_ready;
    assign ready_b  = !b_valid_reg || ready_o;
    assign ready_a  = !a_valid_reg || ready_b;
    assign in_ready = ready_a;

    // magnitude/3 and remainder, result is 32*q + floor(32*r/3)
    assign quo  = b_prod_reg[63:33];
    assign rem  = 2'(b_mag_reg - ({1'b0, quo} + {quo, 1'b0}));
    assign frac = (rem == 2'd1) ? 5'd10 : ((rem == 2'd2) ? 5'd21 : 5'd0);
    assign mag36       = {quo, frac};
    assign scaled_next = b_neg_reg ? (36'd0 - mag36) : mag36;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (ready_a) begin
                a_valid_reg <= in_valid;
            end
            if (ready_b) begin
                b_valid_reg <= a_valid_reg;
            end
            if (ready_o) begin
                o_valid_reg <= b_valid_reg;
            end
        end
    end

    // payload stages: sign split, reciprocal multiply, fix-up and sign restore
    always_ff @(posedge aclk) begin
        if (ready_a) begin
            a_item_reg <= in_item;
            a_neg_reg  <= in_item.raw[31];
            a_mag_reg  <= in_item.raw[31] ? (32'd0 - in_item.raw) : in_item.raw;
        end
        if (ready_b) begin
            b_item_reg <= a_item_reg;
            b_neg_reg  <= a_neg_reg;
            b_mag_reg  <= a_mag_reg;
            b_prod_reg <= a_mag_reg * RECIP3;
        end
        if (ready_o) begin
            o_item_reg   <= b_item_reg;
            o_scaled_reg <= scaled_next;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_item   = o_item_reg;
    assign out_scaled = o_scaled_reg;

endmodule
`default_nettype wire

/* rtl/core/eeg_packet_deframer_unit.sv */
// a completing byte's result is queued, then passes back stages a, b, o to m_*
// throughput: one byte per cycle while s_tready is high; full result queue drops it
// after a configuration write, s_tready stays low while the window taps reload
// reset: synchronous, active-low aresetn clears control state and sets channel_count to 32
// the window memory is not cleared; only bytes written since the last flush are read
`default_nettype none
module eeg_packet_deframer_unit #(
    parameter int WINDOW_DEPTH = 256,
    parameter int MAX_CHANNELS = 32
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  wire logic         s_tuser,   // [0] op
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [103:0]      m_tdata,   // [31:0] sequence_res, [36:32] channel,
                                         // [72:37] scaled_sample, [80:73] lead_off_bits,
                                         // [83:81] lead_off_index, [91:84] mark_byte,
                                         // [99:92] debug_byte, [103:100] zero
    output logic [2:0]        m_tuser,   // [2:0] kind
    output logic              m_tlast,
    // configuration port
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import epd_pkg::*;

    logic [5:0]  cc_reg;
    logic        cfg_wr;
    logic        q_full, push, fifo_valid, back_ready;
    epd_item_t   push_item, fifo_item, out_item;
    logic [35:0] out_scaled;

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_CHANNEL_COUNT);
    assign prdata = (paddr == ADDR_CHANNEL_COUNT) ? {26'd0, cc_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= CHANNEL_RESET;
        end else if (cfg_wr) begin
            cc_reg <= pwdata[5:0];
        end
    end

    epd_front #(
        .WINDOW_DEPTH(WINDOW_DEPTH),
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .channel_count (cc_reg),
        .cfg_wr        (cfg_wr),
        .in_valid      (s_tvalid),
        .in_flush      (s_tuser),
        .in_byte       (s_tdata),
        .in_ready      (s_tready),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    epd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop_valid (fifo_valid),
        .pop       (back_ready),
        .pop_item  (fifo_item)
    );

    epd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (fifo_valid),
        .in_item    (fifo_item),
        .in_ready   (back_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_item   (out_item),
        .out_scaled (out_scaled)
    );

    // result packing
    assign m_tdata = {4'd0, out_item.dbg, out_item.mark, out_item.lead_idx,
                      out_item.lead_bits, out_scaled, out_item.channel, out_item.seq};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule
`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import epd_pkg::*;

    // one expected parser result
    typedef struct {
        epd_kind_t   kind;
        bit [31:0]   seq;
        bit [4:0]    channel;
        bit [35:0]   scaled;
        bit [7:0]    lead_bits;
        bit [2:0]    lead_idx;
        bit [7:0]    mark;
        bit [7:0]    dbg;
        bit          last;
    } frame_result_t;

    // one input request
    typedef struct {
        bit       op;
        bit [7:0] data;
    } rx_req_t;

    // predictor of the deframer and store of pending results
    class deframer_scoreboard;
        bit [7:0]      win[256];
        int            fill;
        int            wp;
        bit            locked;
        bit [31:0]     last_seq;
        bit [31:0]     hdr_seq;
        int            pos;
        int            dbg_len;
        bit [31:0]     acc;
        int            chans;
        frame_result_t pending[$];
        int            errors;

        function new();
            fill = 0; wp = 0; locked = 0; last_seq = 0; hdr_seq = 0;
            pos = 0; dbg_len = 0; acc = 0; chans = 32; errors = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        function bit [7:0] back_byte(int k);
            return win[(wp + 256 - (k % 256)) % 256];
        endfunction

        function bit [31:0] back_word(int k);
            return {back_byte(k - 3), back_byte(k - 2), back_byte(k - 1), back_byte(k)};
        endfunction

        // parse the byte leaving the window
        function bit parse(bit [7:0] b, int n, output frame_result_t r);
            int        off;
            int        k;
            int        idx;
            int        allowed;
            bit [7:0]  mask;
            bit [31:0] raw;
            longint    v;
            longint    s;
            r = '{kind: KIND_MARK, default: 0};
            r.seq = hdr_seq;
            if (pos < 4) begin
                if (pos == 0) hdr_seq = 0;
                hdr_seq |= 32'(b) << (8 * pos);
                r.seq = hdr_seq;
                if (pos == 3) begin
                    if (last_seq + 32'd1 != hdr_seq) begin
                        locked = 0; pos = 0; dbg_len = 0;
                        r.kind = KIND_SEQ_ERR;
                        r.last = 1;
                        return 1;
                    end
                    last_seq = hdr_seq;
                end
                pos++;
                return 0;
            end
            if (pos < 7) begin
                if (pos == 6) dbg_len = b;
                pos++;
                return 0;
            end
            if (pos == 7) begin
                pos = 8;
                if (dbg_len != 0) return 0;
                r.mark = b;
                return 1;
            end
            if (dbg_len != 0) begin
                dbg_len--;
                r.kind = KIND_DEBUG;
                r.dbg = b;
                if (dbg_len == 0) begin
                    r.last = 1;
                    pos = 0;
                end
                return 1;
            end
            off = pos - 8;
            if (off < 4 * n) begin
                k = off & 3;
                pos++;
                if (k == 0) acc = 0;
                if (k < 3) begin
                    acc |= 32'(b) << (8 * k);
                    return 0;
                end
                raw = acc | (32'(b) << 24);
                v = longint'($signed(raw));
                s = (v * 256) / 24;
                r.kind = KIND_SAMPLE;
                r.channel = 5'((off >> 2) & 31);
                r.scaled = s[35:0];
                return 1;
            end
            if (off < 4 * n + 8) begin
                idx = off - 4 * n;
                allowed = 2 * n - 8 * idx;
                if (allowed >= 8) mask = 8'hFF;
                else if (allowed <= 0) mask = 8'h00;
                else mask = 8'((1 << allowed) - 1);
                r.kind = KIND_LEAD;
                r.lead_bits = b & mask;
                r.lead_idx = 3'(idx);
                r.last = (idx == 7);
                pos++;
                return 1;
            end
            pos = 0;
            return 0;
        endfunction

        // accepted input request
        function void note_input(bit op, bit [7:0] b);
            int            n;
            int            wlen;
            bit            got;
            bit [31:0]     w1;
            bit [31:0]     w2;
            frame_result_t r;
            n = (chans > 32) ? 32 : chans;
            wlen = 21 + 4 * n;
            got = 0;
            if (op) begin
                fill = 0; locked = 0; pos = 0; dbg_len = 0; acc = 0;
                return;
            end
            if (fill > wlen) fill = wlen;
            if (fill == wlen && locked) got = parse(back_byte(wlen), n, r);
            win[wp] = b;
            wp = (wp + 1) % 256;
            if (fill < wlen) fill++;
            if (!locked && fill == wlen) begin
                w1 = back_word(wlen);
                w2 = back_word(4);
                if (w1 + 32'd1 == w2) begin
                    locked = 1;
                    last_seq = w1 - 32'd1;
                    pos = 0;
                    dbg_len = 0;
                end
            end
            if (got) pending.push_back(r);
        endfunction

        // accepted result against the oldest expectation
        task check_result(bit [2:0] kind, bit [103:0] d, bit last);
            frame_result_t e;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result kind %0d seq %h", kind, d[31:0]));
                return;
            end
            e = pending.pop_front();
            if (kind != e.kind)
                report($sformatf("kind %0d, want %0d", kind, e.kind));
            if (d[31:0] != e.seq)
                report($sformatf("sequence %h, want %h", d[31:0], e.seq));
            if (d[36:32] != e.channel)
                report($sformatf("channel %0d, want %0d", d[36:32], e.channel));
            if (d[72:37] != e.scaled)
                report($sformatf("sample %h, want %h", d[72:37], e.scaled));
            if (d[80:73] != e.lead_bits)
                report($sformatf("lead-off bits %h, want %h", d[80:73], e.lead_bits));
            if (d[83:81] != e.lead_idx)
                report($sformatf("lead-off index %0d, want %0d", d[83:81], e.lead_idx));
            if (d[91:84] != e.mark)
                report($sformatf("mark %h, want %h", d[91:84], e.mark));
            if (d[99:92] != e.dbg)
                report($sformatf("debug byte %h, want %h", d[99:92], e.dbg));
            if (d[103:100] != 4'd0)
                report($sformatf("padding %h not zero", d[103:100]));
            if (last != e.last)
                report($sformatf("last %0d, want %0d", last, e.last));
        endtask
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [7:0]   s_tdata = 0;
    logic         s_tuser = 0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         psel = 0;
    logic         penable = 0;
    logic         pwrite = 0;
    logic [2:0]   paddr = 0;
    logic [31:0]  pwdata = 0;
    logic [31:0]  prdata;
    logic         pready;

    eeg_packet_deframer_unit i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    deframer_scoreboard sb = new();
    rx_req_t   stim_q[$];
    bit [31:0] seq_ctr;
    int        cur_chans = 32;
    bit        hold_off_req = 0;
    int        idle_cycles = 0;

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
    end

    // watchdog on cycles without any accepted request or result
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver readiness with random stalls and one long hold-off
    initial begin
        forever begin
            if (hold_off_req) begin
                hold_off_req = 0;
                m_tready <= 0;
                repeat (800) @(posedge aclk);
            end
            m_tready <= 1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(30, 150)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            m_tready <= 0;
            if ($urandom_range(0, 11) == 0)
                repeat ($urandom_range(10, 40)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    end

    function void push_byte(bit op, bit [7:0] b);
        rx_req_t q;
        q.op = op;
        q.data = b;
        stim_q.push_back(q);
    endfunction

    function bit [31:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // one packet: data when dlen is zero, else debug
    function void add_packet(int dlen, bit bad);
        bit [31:0] s;
        bit [31:0] w;
        int        n;
        n = (cur_chans > 32) ? 32 : cur_chans;
        if (bad) begin
            s = $urandom;
        end else begin
            seq_ctr = seq_ctr + 1;
            s = seq_ctr;
        end
        for (int i = 0; i < 4; i++) push_byte(0, s[8*i +: 8]);
        push_byte(0, 8'($urandom));
        push_byte(0, 8'($urandom));
        push_byte(0, 8'(dlen));
        push_byte(0, 8'($urandom));
        if (dlen != 0) begin
            for (int i = 0; i < dlen; i++) push_byte(0, 8'($urandom));
            return;
        end
        for (int c = 0; c < n; c++) begin
            w = rand_sample();
            for (int i = 0; i < 4; i++) push_byte(0, w[8*i +: 8]);
        end
        for (int i = 0; i < 9; i++)
            push_byte(0, ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
    endfunction

    // mostly well-formed packet streams, some noise, bad sequences and flushes
    function void gen_phase(int target);
        int r;
        add_packet(0, 0);
        add_packet(0, 0);
        while (stim_q.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 68) add_packet(0, 0);
            else if (r < 80) add_packet($urandom_range(1, 6), 0);
            else if (r < 86) add_packet(0, 1);
            else if (r < 93) begin
                repeat ($urandom_range(1, 5)) push_byte(0, 8'($urandom));
            end else begin
                push_byte(1, 8'($urandom));
                add_packet(0, 0);
                add_packet(0, 0);
            end
        end
    endfunction

    // send every queued request with random gaps
    task drive_all();
        rx_req_t q;
        int      gap;
        while (stim_q.size() > 0) begin
            q = stim_q.pop_front();
            s_tvalid <= 1;
            s_tdata <= q.data;
            s_tuser <= q.op;
            do @(posedge aclk); while (!s_tready);
            sb.note_input(q.op, q.data);
            gap = 0;
            if ($urandom_range(0, 99) < 5) gap = $urandom_range(10, 40);
            else if ($urandom_range(0, 99) < 35) gap = $urandom_range(1, 3);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 0;
    endtask

    task wait_drained();
        while (sb.pending.size() > 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    // register write, setup then access
    task apb_write(bit [2:0] addr, bit [31:0] value);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= value;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        sb.chans = value & 32'h3F;
        cur_chans = value & 32'h3F;
    endtask

    initial begin
        int cfgs[9];
        int targets[9];
        cfgs = '{32, 1, 0, 63, 3, 2, 4, 5, 8};
        targets = '{250, 60, 60, 250, 60, 60, 60, 60, 60};
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        for (int p = 0; p < 9; p++) begin
            if (p > 0) apb_write(ADDR_CHANNEL_COUNT, cfgs[p]);
            seq_ctr = (p % 3 == 0) ? 32'hFFFF_FFFB : $urandom;
            gen_phase(targets[p]);
            if (p == 0) hold_off_req = 1;
            drive_all();
            wait_drained();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
